>>> rtl/c2h_pkg.sv
package c2h_pkg;

    // Mode slots, coordinate width and the fixed widths of the item fields
    localparam int MODE_SLOTS = 4;
    localparam int COORD_BITS = 32;
    localparam int OFF_W      = 8;
    localparam int BSIZE_W    = 8;
    localparam int ORDER_W    = 3;
    localparam int CNT_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int STEP_W     = $clog2(COORD_BITS);

    // Stream payload widths
    localparam int S_TDATA_W = MODE_SLOTS * COORD_BITS + VALUE_W;
    localparam int M_TDATA_W = CNT_W + MODE_SLOTS * COORD_BITS
                               + MODE_SLOTS * OFF_W + VALUE_W + CNT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TENSOR_ORDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 1'b1;

    // Reset values of the configuration registers, the four-mode order code and the base mode count
    localparam logic [ORDER_W-1:0] ORDER_RESET  = 3'd3;
    localparam logic [ORDER_W-1:0] ORDER_FOUR   = 3'd4;
    localparam logic [BSIZE_W-1:0] BSIZE_RESET  = 8'd128;
    localparam int                 BASE_MODES   = 3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV   = 3'b010,
        ST_MERGE = 3'b100
    } t_state;

    // One divider lane's status and answer
    typedef struct packed {
        logic                  done;
        logic [COORD_BITS-1:0] quot;
        logic [OFF_W-1:0]      rem;
    } t_lane_out;

    // Merged result of one item (value travels separately)
    typedef struct packed {
        logic                                   new_block;
        logic [CNT_W-1:0]                       block_number;
        logic [MODE_SLOTS-1:0][COORD_BITS-1:0]  blk;
        logic [MODE_SLOTS-1:0][OFF_W-1:0]       off;
        logic [CNT_W-1:0]                       count;
    } t_result;

endpackage

>>> rtl/c2h_div_lane.sv
module c2h_div_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [c2h_pkg::COORD_BITS-1:0]    i_dividend,
    input  logic [c2h_pkg::BSIZE_W-1:0]       i_divisor,
    output c2h_pkg::t_lane_out                o_res
);

    logic                               r_busy;
    logic                               r_done;
    logic [c2h_pkg::STEP_W-1:0]         r_cnt;
    logic [c2h_pkg::COORD_BITS-1:0]     r_work;
    logic [c2h_pkg::OFF_W-1:0]          r_rem;
    logic [c2h_pkg::BSIZE_W-1:0]        r_div;

    logic [c2h_pkg::OFF_W:0]            w_shifted;
    logic [c2h_pkg::OFF_W:0]            w_diff;
    logic                               w_ge;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign w_shifted = {r_rem, r_work[c2h_pkg::COORD_BITS-1]};
    assign w_ge      = (w_shifted >= {1'b0, r_div});
    assign w_diff    = w_shifted - {1'b0, r_div};

    // Control: run one step per cycle, flag done after the last bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == c2h_pkg::STEP_W'(c2h_pkg::COORD_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: quotient bits shift into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_work <= {r_work[c2h_pkg::COORD_BITS-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[c2h_pkg::OFF_W-1:0] : w_shifted[c2h_pkg::OFF_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_work;
    assign o_res.rem  = r_rem;

endmodule

>>> rtl/c2h_merge.sv
module c2h_merge (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_fire,
    input  logic                                       i_first,
    input  logic                                       i_modes4,
    input  c2h_pkg::t_lane_out [c2h_pkg::MODE_SLOTS-1:0] i_lane,
    output c2h_pkg::t_result                           o_res
);

    logic [c2h_pkg::MODE_SLOTS-1:0][c2h_pkg::COORD_BITS-1:0] r_held;
    logic [c2h_pkg::MODE_SLOTS-1:0][c2h_pkg::COORD_BITS-1:0] n_held;
    logic                                                    r_open;
    logic [c2h_pkg::CNT_W-1:0]                               r_counter;
    logic [c2h_pkg::CNT_W-1:0]                               n_counter;
    logic [c2h_pkg::CNT_W-1:0]                               r_tally;
    logic [c2h_pkg::CNT_W-1:0]                               n_tally;

    logic [c2h_pkg::MODE_SLOTS-1:0][c2h_pkg::COORD_BITS-1:0] w_blk;
    logic [c2h_pkg::MODE_SLOTS-1:0][c2h_pkg::OFF_W-1:0]      w_off;
    logic [c2h_pkg::MODE_SLOTS-1:0]                          w_diff;
    logic                                                    w_start;
    logic                                                    w_opens;

    // Mask inactive modes and compare each lane with the held block
    always_comb begin
        for (int i = 0; i < c2h_pkg::MODE_SLOTS; i++) begin
            if (i < c2h_pkg::BASE_MODES || i_modes4) begin
                w_blk[i]  = i_lane[i].quot;
                w_off[i]  = i_lane[i].rem;
                w_diff[i] = (i_lane[i].quot != r_held[i]);
            end else begin
                w_blk[i]  = '0;
                w_off[i]  = '0;
                w_diff[i] = 1'b0;
            end
        end
    end

    assign w_start = i_first || !r_open;
    assign w_opens = w_start || (|w_diff);

    // Next block state
    always_comb begin
        n_held    = r_held;
        n_counter = r_counter;
        n_tally   = r_tally;
        if (w_opens) begin
            n_held    = w_blk;
            n_counter = w_start ? '0 : r_counter + 1'b1;
            n_tally   = c2h_pkg::CNT_W'(1);
        end else if (r_tally != '1) begin
            n_tally = r_tally + 1'b1;
        end
    end

    // Commit when the result is taken into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_open    <= 1'b0;
            r_counter <= '0;
            r_tally   <= '0;
        end else if (i_fire) begin
            r_held    <= n_held;
            r_open    <= 1'b1;
            r_counter <= n_counter;
            r_tally   <= n_tally;
        end
    end

    assign o_res.new_block    = w_opens;
    assign o_res.block_number = n_counter;
    assign o_res.blk          = n_held;
    assign o_res.off          = w_off;
    assign o_res.count        = n_tally;

endmodule

>>> rtl/coo_to_hicoo_blocker_unit.sv
// Sparse tensor blocker: turns a sorted stream of 3- or 4-mode nonzeros into
// cubic blocks, one result item per input item.
// Input channel (i_s_*): coordinates and value in tdata, first-of-tensor flag
// in tuser. Output channel (o_m_*): block number, block coordinates, in-block
// offsets, value and per-block count in tdata, new-block flag in tuser.
// Config channel (i_cfg_*): index 0 = tensor order, index 1 = block size;
// always ready, write only while no item is in flight.
// Four divider lanes split the coordinates in parallel, one quotient bit per
// cycle; the item then passes to a merge step that compares against the held
// block and loads the output register. A new item is accepted only once the
// previous one has been merged and the sequencer is back in idle, so items
// never overlap in the lanes.
// The output register holds a finished item while the next one is already
// accepted and divided; if that item is still waiting when the next merge is
// due, the merge holds until the receiver takes it.
// Reset (synchronous, active low) restores order 3, block size 128, clears
// the held block, block counter and tally, and empties the output register.
module coo_to_hicoo_blocker_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [c2h_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [c2h_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // coord_a[31:0], coord_b[63:32], coord_c[95:64], coord_d[127:96], nz_value[159:128]
    input  logic [c2h_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // first_item[0]
    input  logic                              i_s_tuser,
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // block_number[31:0], blk_a[63:32], blk_b[95:64], blk_c[127:96], blk_d[159:128],
    // off_a[167:160], off_b[175:168], off_c[183:176], off_d[191:184],
    // value_out[223:192], count_in_block[255:224]
    output logic [c2h_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // new_block[0]
    output logic                              o_m_tuser
);

    c2h_pkg::t_state                                r_state;
    c2h_pkg::t_state                                n_state;
    logic [c2h_pkg::ORDER_W-1:0]                    r_order;
    logic [c2h_pkg::BSIZE_W-1:0]                    r_bsize;
    logic                                           r_first;
    logic [c2h_pkg::VALUE_W-1:0]                    r_value;
    logic                                           r_out_valid;
    c2h_pkg::t_result                               r_out;
    logic [c2h_pkg::VALUE_W-1:0]                    r_out_value;

    c2h_pkg::t_lane_out [c2h_pkg::MODE_SLOTS-1:0]   w_lane;
    logic [c2h_pkg::MODE_SLOTS-1:0]                 w_lane_done;
    c2h_pkg::t_result                               w_res;
    logic [c2h_pkg::BSIZE_W-1:0]                    w_divisor;
    logic                                           w_in_acc;
    logic                                           w_out_acc;
    logic                                           w_load;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == c2h_pkg::ST_IDLE);
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_out_acc   = r_out_valid && i_m_tready;
    assign w_load      = (r_state == c2h_pkg::ST_MERGE) && (!r_out_valid || i_m_tready);
    assign w_divisor   = (r_bsize == '0) ? c2h_pkg::BSIZE_W'(1) : r_bsize;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= c2h_pkg::ORDER_RESET;
            r_bsize <= c2h_pkg::BSIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                c2h_pkg::CFG_TENSOR_ORDER: r_order <= i_cfg_data[c2h_pkg::ORDER_W-1:0];
                c2h_pkg::CFG_BLOCK_SIZE:   r_bsize <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Divider lanes, one per mode
    for (genvar g = 0; g < c2h_pkg::MODE_SLOTS; g++) begin : g_lane
        c2h_div_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (w_in_acc),
            .i_dividend (i_s_tdata[g*c2h_pkg::COORD_BITS +: c2h_pkg::COORD_BITS]),
            .i_divisor  (w_divisor),
            .o_res      (w_lane[g])
        );
        assign w_lane_done[g] = w_lane[g].done;
    end

    // Merge lanes against the held block
    c2h_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_load),
        .i_first  (r_first),
        .i_modes4 (r_order == c2h_pkg::ORDER_FOUR),
        .i_lane   (w_lane),
        .o_res    (w_res)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            c2h_pkg::ST_IDLE:  if (w_in_acc) n_state = c2h_pkg::ST_DIV;
            c2h_pkg::ST_DIV:   if (&w_lane_done) n_state = c2h_pkg::ST_MERGE;
            c2h_pkg::ST_MERGE: if (w_load) n_state = c2h_pkg::ST_IDLE;
            default:           n_state = c2h_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c2h_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the flag and value of the accepted item
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_first <= i_s_tuser;
            r_value <= i_s_tdata[c2h_pkg::MODE_SLOTS*c2h_pkg::COORD_BITS +: c2h_pkg::VALUE_W];
        end
    end

    // Output register: load on merge, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out       <= w_res;
            r_out_value <= r_value;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.new_block;
    assign o_m_tdata  = {r_out.count, r_out_value,
                         r_out.off[3], r_out.off[2], r_out.off[1], r_out.off[0],
                         r_out.blk[3], r_out.blk[2], r_out.blk[1], r_out.blk[0],
                         r_out.block_number};

    // An accepted item always enters the lanes next
    a_acc_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == c2h_pkg::ST_DIV))
        else $error("accepted item did not start division");

    // Lanes run in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == c2h_pkg::ST_DIV) |-> (w_lane_done == '0 || w_lane_done == '1))
        else $error("divider lanes out of step");

    // A first item restarts block numbering
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_first) |=> (r_out.block_number == '0 && r_out.new_block))
        else $error("first item did not restart block number");

    // A new block always starts its count at one
    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.new_block) |-> (r_out.count == c2h_pkg::CNT_W'(1)))
        else $error("new block count not one");

endmodule
